// ===== hdl/bb_pkg.sv =====
`default_nettype none
package bb_pkg;

  // build-time defaults
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 8;

  // configuration register sizes
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int ROW_W        = HEIGHT_REG_W;

  // a sum of up to nine channel values needs four extra bits
  localparam int SUM_EXTRA = 4;
  // neighbour count is at most nine
  localparam int COUNT_W   = 4;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  // register indexes
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // which border rows and columns of the window take part
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } mask_t;

endpackage
`default_nettype wire

// ===== hdl/bb_line_store.sv =====
`default_nettype none
module bb_line_store #(
  parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF,
  parameter int PIX_W     = 3 * bb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic      [PIX_W-1:0]             top_q,
  output logic      [PIX_W-1:0]             mid_q,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]             wr_top,
  input  wire logic [PIX_W-1:0]             wr_mid
);

  // two rows back and one row back
  logic [PIX_W-1:0] mem_top [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_q <= mem_top[rd_addr];
      mid_q <= mem_mid[rd_addr];
    end
  end

  // write back the shifted column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_top[wr_addr] <= wr_top;
      mem_mid[wr_addr] <= wr_mid;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bb_window.sv =====
`default_nettype none
module bb_window #(
  parameter int CHANNEL_BITS = bb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                               clk,
  input  wire logic                                               shift,
  input  wire logic [3*CHANNEL_BITS-1:0]                          top_col,
  input  wire logic [3*CHANNEL_BITS-1:0]                          mid_col,
  input  wire logic [3*CHANNEL_BITS-1:0]                          bot_col,
  input  wire bb_pkg::mask_t                                      mask,
  output logic      [2:0][CHANNEL_BITS+bb_pkg::SUM_EXTRA-1:0]     sum
);

  localparam int PIX_W = 3 * CHANNEL_BITS;
  localparam int SUM_W = CHANNEL_BITS + bb_pkg::SUM_EXTRA;

  // [row][column], column 2 is the newest
  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0]                 row_keep;
  logic [2:0]                 col_keep;

  // shift one column in
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= top_col;
      win[1][2] <= mid_col;
      win[2][2] <= bot_col;
    end
  end

  // border masks
  assign row_keep = {mask.down, 1'b1, mask.up};
  assign col_keep = {mask.right, 1'b1, mask.left};

  // masked sum per channel
  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (row_keep[i] && col_keep[j]) begin
            sum[k] = sum[k] + SUM_W'(win[i][j][k*CHANNEL_BITS +: CHANNEL_BITS]);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bb_divider.sv =====
`default_nettype none
module bb_divider #(
  parameter int CHANNEL_BITS = bb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           start,
  input  wire logic [bb_pkg::COUNT_W-1:0]                     divisor,
  input  wire logic [2:0][CHANNEL_BITS+bb_pkg::SUM_EXTRA-1:0] dividend,
  output logic                                                busy,
  output logic      [2:0][CHANNEL_BITS-1:0]                   quotient
);

  localparam int SUM_W = CHANNEL_BITS + bb_pkg::SUM_EXTRA;
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int DW    = bb_pkg::COUNT_W;

  logic [CNT_W-1:0]          steps;
  logic [DW-1:0]             dvs;
  logic [2:0][SUM_W-1:0]     quo;
  logic [2:0][DW-1:0]        rem;
  logic [2:0][DW:0]          trial;
  logic [2:0]                fits;

  // one restoring step per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem[k], quo[k][SUM_W-1]};
      fits[k]  = trial[k] >= {1'b0, dvs};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= CNT_W'(SUM_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // shift and subtract, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (steps != '0) begin
      for (int k = 0; k < 3; k++) begin
        rem[k] <= fits[k] ? DW'(trial[k] - {1'b0, dvs}) : trial[k][DW-1:0];
        quo[k] <= {quo[k][SUM_W-2:0], fits[k]};
      end
    end
  end

  assign busy = steps != '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quotient[k] = quo[k][CHANNEL_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/box_blur_3x3_top.sv =====
`default_nettype none
// Streaming 3x3 box blur of an RGB frame given in raster order, one pixel per input beat.
// Each result is the truncated per-channel mean of the in-frame pixels around it, so
// edges and corners divide by their own neighbour count. Results lag by one row plus
// one pixel; after the last pixel send image_width+1 flush beats, and the final result
// carries frame_last. Flush beats before the frame is complete are dropped, and a pixel
// after the frame or during the drain starts a new frame. A dropped flush is taken while
// idle; a beat that gives no result passes the read state (line store read, then write
// back), and a beat that gives a result goes on through the sum state and the radix-2
// divider that divides the three channel sums by the neighbour count, and waits there
// while the output is stalled. The input stalls until the sequencer is idle. The line
// store is not cleared after reset; border pixels outside the frame are masked out, so
// its unwritten contents never reach a result.
module box_blur_3x3_top #(
  parameter int MAX_WIDTH    = bb_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CHANNEL_BITS-1:0]       red_in,
  input  wire logic [CHANNEL_BITS-1:0]       green_in,
  input  wire logic [CHANNEL_BITS-1:0]       blue_in,
  input  wire logic                          flush,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [CHANNEL_BITS-1:0]       red_out,
  output logic      [CHANNEL_BITS-1:0]       green_out,
  output logic      [CHANNEL_BITS-1:0]       blue_out,
  output logic                               frame_last
);

  localparam int PIX_W = 3 * CHANNEL_BITS;
  localparam int SUM_W = CHANNEL_BITS + bb_pkg::SUM_EXTRA;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int WW    = (CW > bb_pkg::WIDTH_REG_W) ? CW : bb_pkg::WIDTH_REG_W;
  localparam int RW    = bb_pkg::ROW_W;
  localparam int QW    = RW + 1;
  localparam int NW    = bb_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SUM  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t st;

  logic [bb_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [bb_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [WW-1:0]                   eff_w;
  logic [RW-1:0]                   eff_h;

  logic [WW-1:0] col_cnt, col_next;
  logic [RW-1:0] row_cnt, row_next;
  logic [WW-1:0] drain_cnt, drain_next;
  logic [WW-1:0] c_tmp;
  logic [RW-1:0] r_tmp;
  logic          accept;
  logic          item_act;
  logic          a_rd;

  logic [PIX_W-1:0] item_pix;
  logic             item_is_pix;
  logic [WW-1:0]    item_c;
  logic [RW-1:0]    item_r;
  logic             item_rd;

  logic [PIX_W-1:0] top_q, mid_q;
  logic [PIX_W-1:0] top_col, mid_col, bot_col;

  logic [WW-1:0]    qc;
  logic [QW-1:0]    qr2;
  logic [QW-1:0]    h_ext;
  logic             res_ok;
  bb_pkg::mask_t    mask_now, mask;
  logic [1:0]       rows_n, cols_n;
  logic [NW-1:0]    cnt_now, cnt;
  logic             last_now, last;

  logic [2:0][SUM_W-1:0]        sum;
  logic [2:0][CHANNEL_BITS-1:0] quotient;
  logic                         div_busy;
  logic                         out_free;
  logic                         out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb_pkg::WIDTH_RESET;
      image_height <= bb_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bb_pkg::WIDTH_REG_W-1:0];
        bb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bb_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, width clamped to the store
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    eff_h = (image_height == '0) ? RW'(1) : image_height;
  end

  assign in_stall = st != S_IDLE;
  assign accept   = in_valid && !in_stall;

  // position bookkeeping for the beat on offer
  always_comb begin
    col_next   = col_cnt;
    row_next   = row_cnt;
    drain_next = drain_cnt;
    item_act   = 1'b1;
    a_rd       = 1'b0;
    c_tmp      = col_cnt;
    r_tmp      = row_cnt;
    if (!flush) begin
      if (c_tmp >= eff_w) begin
        c_tmp = '0;
        r_tmp = row_cnt + 1'b1;
      end
      if (r_tmp >= eff_h || drain_cnt != '0) begin
        c_tmp = '0;
        r_tmp = '0;
      end
      drain_next = '0;
      a_rd       = 1'b1;
      col_next   = c_tmp + 1'b1;
      row_next   = r_tmp;
      if (col_next >= eff_w) begin
        col_next = '0;
        row_next = r_tmp + 1'b1;
      end
    end else if (row_cnt < eff_h) begin
      // early flush is dropped
      item_act = 1'b0;
    end else begin
      c_tmp = (drain_cnt > eff_w) ? eff_w : drain_cnt;
      r_tmp = eff_h;
      a_rd  = c_tmp < eff_w;
      if (c_tmp == eff_w) begin
        col_next   = '0;
        row_next   = '0;
        drain_next = '0;
      end else begin
        drain_next = c_tmp + 1'b1;
      end
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      drain_cnt <= '0;
    end else if (accept) begin
      col_cnt   <= col_next;
      row_cnt   <= row_next;
      drain_cnt <= drain_next;
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pix    <= {blue_in, green_in, red_in};
      item_is_pix <= !flush;
      item_c      <= c_tmp;
      item_r      <= r_tmp;
      item_rd     <= a_rd;
    end
  end

  bb_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIX_W     (PIX_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept && item_act && a_rd),
    .rd_addr (c_tmp[AW-1:0]),
    .top_q   (top_q),
    .mid_q   (mid_q),
    .wr_en   (st == S_READ && item_is_pix),
    .wr_addr (item_c[AW-1:0]),
    .wr_top  (mid_q),
    .wr_mid  (item_pix)
  );

  // new window column
  assign top_col = item_rd ? top_q : '0;
  assign mid_col = item_rd ? mid_q : '0;
  assign bot_col = item_is_pix ? item_pix : '0;

  // centre of the result and its border masks
  always_comb begin
    h_ext = QW'(eff_h);
    if (item_c != '0) begin
      qc  = item_c - 1'b1;
      qr2 = QW'(item_r) + 1'b1;
    end else begin
      qc  = eff_w - 1'b1;
      qr2 = QW'(item_r);
    end
    res_ok         = qr2 >= QW'(2) && qr2 < h_ext + QW'(2);
    mask_now.up    = qr2 >= QW'(3);
    mask_now.down  = qr2 < h_ext + QW'(1);
    mask_now.left  = qc != '0;
    mask_now.right = qc + 1'b1 < eff_w;
    rows_n   = 2'd1 + 2'(mask_now.up) + 2'(mask_now.down);
    cols_n   = 2'd1 + 2'(mask_now.left) + 2'(mask_now.right);
    cnt_now  = NW'(rows_n) * NW'(cols_n);
    last_now = qr2 == h_ext + QW'(1) && qc == eff_w - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (st == S_READ) begin
      mask <= mask_now;
      cnt  <= cnt_now;
      last <= last_now;
    end
  end

  bb_window #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_window (
    .clk     (clk),
    .shift   (st == S_READ),
    .top_col (top_col),
    .mid_col (mid_col),
    .bot_col (bot_col),
    .mask    (mask),
    .sum     (sum)
  );

  bb_divider #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (st == S_SUM),
    .divisor  (cnt),
    .dividend (sum),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_free = !out_valid || !out_stall;
  assign out_load = st == S_DIV && !div_busy && out_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept && item_act) st <= S_READ;
        end
        S_READ: begin
          st <= res_ok ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          st <= S_DIV;
        end
        S_DIV: begin
          if (out_load) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out    <= quotient[0];
      green_out  <= quotient[1];
      blue_out   <= quotient[2];
      frame_last <= last;
    end
  end

endmodule
`default_nettype wire

// ===== dv/box_blur_3x3_checker.sv =====
module box_blur_3x3_checker #(
  parameter int MAX_W = bb_pkg::MAX_WIDTH_DEF,
  parameter int CB    = bb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [CB-1:0]                 red_in,
  input  wire logic [CB-1:0]                 green_in,
  input  wire logic [CB-1:0]                 blue_in,
  input  wire logic                          flush,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [CB-1:0]                 red_out,
  input  wire logic [CB-1:0]                 green_out,
  input  wire logic [CB-1:0]                 blue_out,
  input  wire logic                          frame_last,
  output int                                 errors,
  output int                                 pending
);

  localparam int PIX_W = 3 * CB;

  typedef struct {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          last;
  } blurred_px_t;

  // blurred pixels still owed by the block, oldest first
  blurred_px_t blurred_q[$];

  // own copy of the registers and the filter state
  logic [bb_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [bb_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [PIX_W-1:0]                line_mem [2*MAX_W];
  logic [PIX_W-1:0]                win [3][3];
  int                              col_pos;
  int                              row_pos;
  int                              drain_pos;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [CB-1:0] got,
                             input logic [CB-1:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // advance the filter by one beat and queue the blurred pixel it yields
  task automatic blur_step(input logic [CB-1:0] r_in, input logic [CB-1:0] g_in,
                           input logic [CB-1:0] b_in, input logic is_flush);
    int w;
    int h;
    int c;
    int r;
    int qr;
    int qc;
    int cnt;
    int sums [3];
    bit has_up;
    bit has_down;
    bit has_left;
    bit has_right;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic [PIX_W-1:0] bot_px;
    blurred_px_t res;

    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = int'(height_reg);
    if (h == 0) h = 1;

    if (!is_flush) begin
      // pixel: wrap the column, start a new frame if the old one is done
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h || drain_pos != 0) begin
        col_pos   = 0;
        row_pos   = 0;
        drain_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      top_px = line_mem[MAX_W + c];
      mid_px = line_mem[c];
      bot_px = {b_in, g_in, r_in};
      line_mem[MAX_W + c] = mid_px;
      line_mem[c]         = bot_px;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      // flush before the frame is complete is dropped
      if (row_pos < h) return;
      c = (drain_pos > w) ? w : drain_pos;
      r = h;
      if (c < w) begin
        top_px = line_mem[MAX_W + c];
        mid_px = line_mem[c];
      end else begin
        top_px = '0;
        mid_px = '0;
      end
      bot_px = '0;
      if (c == w) begin
        col_pos   = 0;
        row_pos   = 0;
        drain_pos = 0;
      end else begin
        drain_pos = c + 1;
      end
    end

    // shift the window one column left
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = bot_px;

    // centre position lags by one row plus one pixel
    if (c >= 1) begin
      qr = r - 1;
      qc = c - 1;
    end else begin
      qr = r - 2;
      qc = w - 1;
    end
    if (qr < 0 || qr >= h) return;

    has_up    = qr >= 1;
    has_down  = qr + 1 < h;
    has_left  = qc >= 1;
    has_right = qc + 1 < w;
    cnt = (1 + int'(has_up) + int'(has_down)) * (1 + int'(has_left) + int'(has_right));

    // masked sum per channel
    for (int k = 0; k < 3; k++) begin
      sums[k] = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i == 0 && !has_up) || (i == 2 && !has_down) ||
              (j == 0 && !has_left) || (j == 2 && !has_right)) continue;
          sums[k] += int'(win[i][j][k*CB +: CB]);
        end
      end
    end
    res.red   = CB'(sums[0] / cnt);
    res.green = CB'(sums[1] / cnt);
    res.blue  = CB'(sums[2] / cnt);
    res.last  = (qr == h - 1) && (qc == w - 1);
    blurred_q.push_back(res);
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    blurred_px_t want;
    if (rst) begin
      width_reg  = bb_pkg::WIDTH_RESET;
      height_reg = bb_pkg::HEIGHT_RESET;
      for (int i = 0; i < 2 * MAX_W; i++) line_mem[i] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      col_pos   = 0;
      row_pos   = 0;
      drain_pos = 0;
      blurred_q.delete();
    end else begin
      // compare the result beat first, it can only belong to an earlier pixel
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          report($sformatf("result with nothing expected: %0d %0d %0d last %0b",
                           red_out, green_out, blue_out, frame_last));
        end else begin
          want = blurred_q.pop_front();
          check_field("red_out", red_out, want.red);
          check_field("green_out", green_out, want.green);
          check_field("blue_out", blue_out, want.blue);
          check_field("frame_last", CB'(frame_last), CB'(want.last));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          bb_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data[bb_pkg::WIDTH_REG_W-1:0];
          bb_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data[bb_pkg::HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        blur_step(red_in, green_in, blue_in, flush);
      end
    end
    pending = blurred_q.size();
  end

endmodule

// ===== dv/tb_box_blur_3x3_top.sv =====
module tb_box_blur_3x3_top;

  localparam int CB            = bb_pkg::CHANNEL_BITS_DEF;
  localparam int MAXW          = bb_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 700;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [0:0]                    cfg_index = bb_pkg::REG_IMAGE_WIDTH;
  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic [CB-1:0]                 red_in    = '0;
  logic [CB-1:0]                 green_in  = '0;
  logic [CB-1:0]                 blue_in   = '0;
  logic                          flush     = 1'b0;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [CB-1:0]                 red_out;
  logic [CB-1:0]                 green_out;
  logic [CB-1:0]                 blue_out;
  logic                          frame_last;

  // no idling on either side while set
  bit calm = 1'b0;
  int frame_w = 1;
  int frame_h = 1;
  int items = 0;
  int errors;
  int pending;

  box_blur_3x3_top i_dut (.*);

  box_blur_3x3_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls now and then
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  function automatic logic [CB-1:0] pick_chan();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return CB'($urandom);
  endfunction

  // one input beat, with an occasional gap in front of it
  task automatic send_beat(input logic [CB-1:0] r, input logic [CB-1:0] g,
                           input logic [CB-1:0] b, input logic fl);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    flush    <= fl;
    do @(posedge clk); while (in_stall);
  endtask

  // random pixels, with stray flushes before the frame is complete
  task automatic send_pixels(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < noise_pct) begin
        send_beat(pick_chan(), pick_chan(), pick_chan(), 1'b1);
      end
      send_beat(pick_chan(), pick_chan(), pick_chan(), 1'b0);
      items++;
    end
  endtask

  task automatic drain(input int n);
    repeat (n) begin
      send_beat(pick_chan(), pick_chan(), pick_chan(), 1'b1);
      items++;
    end
  endtask

  // hold off until every blurred pixel is in and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // top data bit is unused by the width register, so toggle it freely
  task automatic write_size(input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= bb_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= bb_pkg::CFG_DATA_W'({1'($urandom_range(1)), bb_pkg::WIDTH_REG_W'(w)});
    @(posedge clk);
    cfg_index <= bb_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= bb_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_w = (w == 0) ? 1 : ((w > MAXW) ? MAXW : w);
    frame_h = (h == 0) ? 1 : h;
  endtask

  initial begin
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x2 frame of extreme values, stray flush ahead of it
    write_size(2, 2);
    send_beat('1, '1, '1, 1'b1);
    send_beat('1, '0, '1, 1'b0);
    send_beat('0, '1, '0, 1'b0);
    send_beat('1, '1, '1, 1'b0);
    send_beat('0, '0, '0, 1'b0);
    // cut the drain short: a pixel restarts the frame
    drain(1);
    repeat (4) send_beat('1, '1, '1, 1'b0);
    // pixel after a complete frame, then a full drain and one flush too many
    send_beat('0, '0, '0, 1'b0);
    send_pixels(3, 0);
    drain(3);
    send_beat('1, '0, '0, 1'b1);

    // width narrowed inside a frame, then again inside the drain
    settle();
    write_size(5, 2);
    send_pixels(3, 0);
    settle();
    write_size(2, 2);
    send_pixels(2, 0);
    drain(2);
    settle();
    write_size(1, 2);
    drain(2);

    // random frames, mostly well formed
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 30) begin
        settle();
        write_size(($urandom_range(99) < 15) ? $urandom_range(13, 48) : $urandom_range(0, 12),
                   ($urandom_range(99) < 15) ? $urandom_range(7, 24) : $urandom_range(0, 6));
      end
      send_pixels(frame_w * frame_h, 5);
      pick = $urandom_range(99);
      if (pick < 85) begin
        drain(frame_w + 1);
      end else begin
        drain($urandom_range(0, frame_w));
      end
    end

    // size extremes
    settle();
    write_size(0, 0);
    send_pixels(1, 0);
    drain(2);
    // long stretch with no idling on either side
    settle();
    calm <= 1'b1;
    write_size(48, 3);
    send_pixels(frame_w * frame_h, 0);
    drain(frame_w + 1);
    calm <= 1'b0;
    // tallest frame, first rows only
    settle();
    write_size(1, 4095);
    send_pixels(64, 5);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bb_pkg.sv
hdl/bb_line_store.sv
hdl/bb_window.sv
hdl/bb_divider.sv
hdl/box_blur_3x3_top.sv
dv/box_blur_3x3_checker.sv
dv/tb_box_blur_3x3_top.sv
